/* rtl/implicit_pic_mass_matrix_coef_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the mass-matrix coefficient kernel
// Shared property forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef IMPLICIT_PIC_MASS_MATRIX_COEF_DEFINES_SVH
`define IMPLICIT_PIC_MASS_MATRIX_COEF_DEFINES_SVH

// same-cycle implication
`define IPMM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipmm check failed");

// next-cycle implication
`define IPMM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipmm check failed");

`endif

/* rtl/ipmm_pkg.sv */
// ----------------------------------------------------------------------------
// ipmm_pkg
// Types, constants and fixed-point helpers for the mass-matrix kernel.
// ----------------------------------------------------------------------------
`default_nettype none
package ipmm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_W     = 32;
    localparam int QUO_W     = FRAC_BITS + 1;
    localparam int REM_W     = DIV_W + QUO_W + 1;

    typedef logic signed [31:0] word_t;
    typedef logic signed [63:0] wide_t;

    localparam word_t ONE    = 32'sd1 <<< FRAC_BITS;
    localparam wide_t RND    = 64'sd1 <<< (FRAC_BITS - 1);
    localparam wide_t MAX_W  = 64'sh0000_0000_7FFF_FFFF;
    localparam wide_t MIN_W  = -64'sh0000_0000_8000_0000;

    localparam logic [1:0] REG_ROT  = 2'd0;
    localparam logic [1:0] REG_INV  = 2'd1;
    localparam logic [1:0] REG_FLOW = 2'd2;

    typedef struct packed {
        word_t [8:0] a;
        word_t [2:0] w;
        word_t       q;
    } side_t;

    function automatic word_t sat64(wide_t x);
        word_t r;
        if (x > MAX_W)
            r = 32'sh7FFF_FFFF;
        else if (x < MIN_W)
            r = -32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic word_t qmul(word_t a, word_t b);
        wide_t ae;
        wide_t be;
        wide_t p;
        ae = 64'(a);
        be = 64'(b);
        p  = ae * be + RND;
        return sat64(p >>> FRAC_BITS);
    endfunction

    function automatic word_t add3(word_t a, word_t b, word_t c);
        return sat64(64'(a) + 64'(b) + 64'(c));
    endfunction

endpackage
`default_nettype wire

/* rtl/implicit_pic_mass_matrix_coef.sv */
// ----------------------------------------------------------------------------
// implicit_pic_mass_matrix_coef
// Per-particle mass-matrix coefficients and implicit current, Q16.16.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries B, velocity, flow velocity and
// charge of one particle; output channel out_valid/out_ready carries the nine
// coefficients and three current components. Config writes go through
// cfg_valid/cfg_ready with cfg_index (0 rotation factor, 1 inverse cell
// volume, 2 flow-frame enable; index 3 is ignored) and cfg_data; cfg_ready is
// always high. Write config only while the pipeline is empty.
// The pipeline has 4 front stages, 17 divider stages (one quotient bit
// of the reciprocal each), 4 back stages, the last being the output register.
// Throughput is one transfer per cycle unless the receiver stalls; then the whole
// pipeline holds, and in_ready drops with it; nothing is lost or repeated.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none
module implicit_pic_mass_matrix_coef import ipmm_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire word_t       b_x,
    input  wire word_t       b_y,
    input  wire word_t       b_z,
    input  wire word_t       vel_x,
    input  wire word_t       vel_y,
    input  wire word_t       vel_z,
    input  wire word_t       flow_x,
    input  wire word_t       flow_y,
    input  wire word_t       flow_z,
    input  wire word_t       particle_charge,
    output logic             out_valid,
    input  wire logic        out_ready,
    output word_t            m_xx,
    output word_t            m_xy,
    output word_t            m_xz,
    output word_t            m_yx,
    output word_t            m_yy,
    output word_t            m_yz,
    output word_t            m_zx,
    output word_t            m_zy,
    output word_t            m_zz,
    output word_t            cur_x,
    output word_t            cur_y,
    output word_t            cur_z
);

    word_t            rot_reg, inv_reg;
    logic             flow_reg;
    logic             en;
    logic             fv, dv;
    logic [DIV_W-1:0] div;
    side_t            fside, dside;
    word_t            denom;
    word_t [8:0]      m;
    word_t [2:0]      cur;

    assign cfg_ready = 1'b1;
    assign en        = !out_valid || out_ready;
    assign in_ready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg  <= '0;
            inv_reg  <= ONE;
            flow_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ROT:  rot_reg  <= cfg_data;
                REG_INV:  inv_reg  <= cfg_data;
                REG_FLOW: flow_reg <= cfg_data[0];
                default:  ;
            endcase
        end
    end

    ipmm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_v    (in_valid),
        .b       ({b_z, b_y, b_x}),
        .vel     ({vel_z, vel_y, vel_x}),
        .flow    ({flow_z, flow_y, flow_x}),
        .q       (particle_charge),
        .rot     (rot_reg),
        .flow_on (flow_reg),
        .out_v   (fv),
        .div     (div),
        .side    (fside)
    );

    ipmm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_v     (fv),
        .div      (div),
        .side_in  (fside),
        .out_v    (dv),
        .denom    (denom),
        .side_out (dside)
    );

    ipmm_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .in_v  (dv),
        .denom (denom),
        .side  (dside),
        .rot   (rot_reg),
        .inv   (inv_reg),
        .out_v (out_valid),
        .m     (m),
        .cur   (cur)
    );

    assign m_xx  = m[0];
    assign m_xy  = m[1];
    assign m_xz  = m[2];
    assign m_yx  = m[3];
    assign m_yy  = m[4];
    assign m_yz  = m[5];
    assign m_zx  = m[6];
    assign m_zy  = m[7];
    assign m_zz  = m[8];
    assign cur_x = cur[0];
    assign cur_y = cur[1];
    assign cur_z = cur[2];

endmodule
`default_nettype wire

/* rtl/ipmm_front.sv */
// ----------------------------------------------------------------------------
// ipmm_front
// Rotation vector, products, sums and divisor: four register stages.
// ----------------------------------------------------------------------------
`default_nettype none
module ipmm_front import ipmm_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_v,
    input  wire word_t [2:0]      b,
    input  wire word_t [2:0]      vel,
    input  wire word_t [2:0]      flow,
    input  wire word_t            q,
    input  wire word_t            rot,
    input  wire logic             flow_on,
    output logic                  out_v,
    output logic [DIV_W-1:0]      div,
    output side_t                 side
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    word_t [2:0] om1_reg, u1_reg;
    word_t       q1_reg;
    word_t [2:0] om1_next, u1_next;

    // p: xx yy zz xy xz yz ; du: u_i*o_i ; cr: uy.oz uz.oy uz.ox ux.oz ux.oy uy.ox
    word_t [5:0] p2_reg, cr2_reg, p2_next, cr2_next;
    word_t [2:0] du2_reg, du2_next, om2_reg, u2_reg;
    word_t       q2_reg;

    word_t       s3_reg, d3_reg, s3_next, d3_next;
    word_t [8:0] a3_reg, a3_next;
    logic signed [32:0] cd3_reg [3];
    logic signed [32:0] cd3_next [3];
    word_t [2:0] om3_reg, u3_reg;
    word_t       q3_reg;

    logic [DIV_W-1:0] div4_reg, div4_next;
    side_t            side4_reg, side4_next;
    word_t [2:0]      dm;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            om1_next[i] = qmul(rot, b[i]);
            u1_next[i]  = flow_on ? sat64(64'(vel[i]) - 64'(flow[i])) : vel[i];
        end
    end

    always_comb
    begin
        p2_next[0] = qmul(om1_reg[0], om1_reg[0]);
        p2_next[1] = qmul(om1_reg[1], om1_reg[1]);
        p2_next[2] = qmul(om1_reg[2], om1_reg[2]);
        p2_next[3] = qmul(om1_reg[0], om1_reg[1]);
        p2_next[4] = qmul(om1_reg[0], om1_reg[2]);
        p2_next[5] = qmul(om1_reg[1], om1_reg[2]);
        for (int i = 0; i < 3; i++)
            du2_next[i] = qmul(u1_reg[i], om1_reg[i]);
        cr2_next[0] = qmul(u1_reg[1], om1_reg[2]);
        cr2_next[1] = qmul(u1_reg[2], om1_reg[1]);
        cr2_next[2] = qmul(u1_reg[2], om1_reg[0]);
        cr2_next[3] = qmul(u1_reg[0], om1_reg[2]);
        cr2_next[4] = qmul(u1_reg[0], om1_reg[1]);
        cr2_next[5] = qmul(u1_reg[1], om1_reg[0]);
    end

    always_comb
    begin
        s3_next    = add3(p2_reg[0], p2_reg[1], p2_reg[2]);
        d3_next    = add3(du2_reg[0], du2_reg[1], du2_reg[2]);
        a3_next[0] = sat64(64'(ONE) + 64'(p2_reg[0]));
        a3_next[1] = sat64(64'(om2_reg[2]) + 64'(p2_reg[3]));
        a3_next[2] = sat64(64'(p2_reg[4]) - 64'(om2_reg[1]));
        a3_next[3] = sat64(64'(p2_reg[3]) - 64'(om2_reg[2]));
        a3_next[4] = sat64(64'(ONE) + 64'(p2_reg[1]));
        a3_next[5] = sat64(64'(om2_reg[0]) + 64'(p2_reg[5]));
        a3_next[6] = sat64(64'(om2_reg[1]) + 64'(p2_reg[4]));
        a3_next[7] = sat64(64'(p2_reg[5]) - 64'(om2_reg[0]));
        a3_next[8] = sat64(64'(ONE) + 64'(p2_reg[2]));
        for (int i = 0; i < 3; i++)
            cd3_next[i] = 33'(cr2_reg[2*i]) - 33'(cr2_reg[2*i+1]);
    end

    always_comb
    begin
        word_t t;
        div4_next    = DIV_W'(s3_reg) + DIV_W'(ONE);
        side4_next.a = a3_reg;
        side4_next.q = q3_reg;
        for (int i = 0; i < 3; i++)
        begin
            dm[i] = qmul(d3_reg, om3_reg[i]);
            t = sat64(64'(cd3_reg[i]) + 64'(dm[i]));
            side4_next.w[i] = sat64(64'(u3_reg[i]) + 64'(t));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_v;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            om1_reg   <= om1_next;
            u1_reg    <= u1_next;
            q1_reg    <= q;
            p2_reg    <= p2_next;
            du2_reg   <= du2_next;
            cr2_reg   <= cr2_next;
            om2_reg   <= om1_reg;
            u2_reg    <= u1_reg;
            q2_reg    <= q1_reg;
            s3_reg    <= s3_next;
            d3_reg    <= d3_next;
            a3_reg    <= a3_next;
            cd3_reg   <= cd3_next;
            om3_reg   <= om2_reg;
            u3_reg    <= u2_reg;
            q3_reg    <= q2_reg;
            div4_reg  <= div4_next;
            side4_reg <= side4_next;
        end
    end

    assign out_v = v4_reg;
    assign div   = div4_reg;
    assign side  = side4_reg;

endmodule
`default_nettype wire

/* rtl/ipmm_div.sv */
// ----------------------------------------------------------------------------
// ipmm_div
// Pipelined restoring divider, one quotient bit per stage, rounded reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none
module ipmm_div import ipmm_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_v,
    input  wire logic [DIV_W-1:0] div,
    input  wire side_t            side_in,
    output logic                  out_v,
    output word_t                 denom,
    output side_t                 side_out
);

    logic             v_reg    [QUO_W];
    logic [REM_W-1:0] rem_reg  [QUO_W];
    logic [REM_W-1:0] rem_next [QUO_W];
    logic [QUO_W-1:0] quo_reg  [QUO_W];
    logic [QUO_W-1:0] quo_next [QUO_W];
    logic [DIV_W-1:0] div_reg  [QUO_W];
    side_t            side_reg [QUO_W];

    always_comb
    begin
        logic [REM_W-1:0] r;
        logic [REM_W-1:0] sh;
        logic [QUO_W-1:0] qp;
        logic [DIV_W-1:0] dp;
        for (int j = 0; j < QUO_W; j++)
        begin
            if (j == 0)
            begin
                r  = (REM_W'(1) << (2 * FRAC_BITS)) + REM_W'(div >> 1);
                qp = '0;
                dp = div;
            end
            else
            begin
                r  = rem_reg[j-1];
                qp = quo_reg[j-1];
                dp = div_reg[j-1];
            end
            sh = REM_W'(dp) << (QUO_W - 1 - j);
            if (r >= sh)
            begin
                rem_next[j] = r - sh;
                quo_next[j] = qp | (QUO_W'(1) << (QUO_W - 1 - j));
            end
            else
            begin
                rem_next[j] = r;
                quo_next[j] = qp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < QUO_W; j++)
                v_reg[j] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_v;
            for (int j = 1; j < QUO_W; j++)
                v_reg[j] <= v_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg[0]  <= div;
            side_reg[0] <= side_in;
            for (int j = 1; j < QUO_W; j++)
            begin
                div_reg[j]  <= div_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
            for (int j = 0; j < QUO_W; j++)
            begin
                rem_reg[j] <= rem_next[j];
                quo_reg[j] <= quo_next[j];
            end
        end
    end

    assign out_v    = v_reg[QUO_W-1];
    assign denom    = 32'(quo_reg[QUO_W-1]);
    assign side_out = side_reg[QUO_W-1];

endmodule
`default_nettype wire

/* rtl/ipmm_back.sv */
// ----------------------------------------------------------------------------
// ipmm_back
// Scale chain and final products; the last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module ipmm_back import ipmm_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   en,
    input  wire logic   in_v,
    input  wire word_t  denom,
    input  wire side_t  side,
    input  wire word_t  rot,
    input  wire word_t  inv,
    output logic        out_v,
    output word_t [8:0] m,
    output word_t [2:0] cur
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    word_t       m1_reg, k1_reg, q1_reg, m2_reg, c0_reg;
    word_t [8:0] a1_reg, a2_reg, a3_reg, m4_reg;
    word_t [2:0] w1_reg, cw2_reg, cw3_reg, cur4_reg;
    word_t [2:0] cw2_next;
    word_t [8:0] m4_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            cw2_next[i] = qmul(w1_reg[i], k1_reg);
        for (int i = 0; i < 9; i++)
            m4_next[i] = qmul(a3_reg[i], c0_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_v;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg   <= qmul(denom, inv);
            k1_reg   <= qmul(denom, side.q);
            q1_reg   <= side.q;
            a1_reg   <= side.a;
            w1_reg   <= side.w;
            m2_reg   <= qmul(m1_reg, q1_reg);
            cw2_reg  <= cw2_next;
            a2_reg   <= a1_reg;
            c0_reg   <= qmul(m2_reg, rot);
            cw3_reg  <= cw2_reg;
            a3_reg   <= a2_reg;
            m4_reg   <= m4_next;
            cur4_reg <= cw3_reg;
        end
    end

    assign out_v = v4_reg;
    assign m     = m4_reg;
    assign cur   = cur4_reg;

endmodule
`default_nettype wire

/* rtl/ipmm_checker.sv */
// ----------------------------------------------------------------------------
// ipmm_checker
// Port-level checks of the kernel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "implicit_pic_mass_matrix_coef_defines.svh"
module ipmm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cfg_ready,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] m_xx,
    input wire logic [31:0] cur_z
);

    `IPMM_ASSERT_NOW(a_ready_follows_out, 1'b1, in_ready == (!out_valid || out_ready))
    `IPMM_ASSERT_NOW(a_cfg_always_ready, 1'b1, cfg_ready)
    `IPMM_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(m_xx) && $stable(cur_z))

endmodule

bind implicit_pic_mass_matrix_coef ipmm_checker u_ipmm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ready (cfg_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .m_xx      (m_xx),
    .cur_z     (cur_z)
);
`default_nettype wire

/* tb/implicit_pic_mass_matrix_coef_tb.sv */
// ----------------------------------------------------------------------------
// Mass-matrix coefficient kernel testbench
// Streams particles through the kernel under bursty input and stalled output,
// predicts the nine coefficients and three current components in Q16.16 and
// compares every output transfer field by field. Configuration changes
// between phases, once the pipeline has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module implicit_pic_mass_matrix_coef_tb;
    import ipmm_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        word_t b[3];
        word_t v[3];
        word_t f[3];
        word_t q;
    } particle_t;

    typedef struct {
        word_t m[9];
        word_t c[3];
    } coef_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;
    logic in_valid;
    logic in_ready;
    word_t b_x, b_y, b_z, vel_x, vel_y, vel_z, flow_x, flow_y, flow_z, particle_charge;
    logic out_valid;
    logic out_ready;
    word_t m_xx, m_xy, m_xz, m_yx, m_yy, m_yz, m_zx, m_zy, m_zz, cur_x, cur_y, cur_z;

    implicit_pic_mass_matrix_coef dut (.*);

    // predictor register copy
    word_t rot_f;
    word_t inv_v;
    logic flow_en;

    particle_t pending[$];
    coef_t expected_coefs[$];
    int n_errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int idle_cycles;
    int burst_left;
    int gap_left;
    int stall_phase;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic word_t sat_w(logic signed [65:0] x);
        if (x > 66'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (x < -66'sd2147483648)
            return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic word_t fx_mul(word_t a, word_t b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b) + (66'sd1 <<< (FRAC_BITS - 1));
        return sat_w(p >>> FRAC_BITS);
    endfunction

    function automatic word_t fx_sum(word_t a, word_t b, word_t c);
        return sat_w(66'(a) + 66'(b) + 66'(c));
    endfunction

    function automatic coef_t predict_coefs(particle_t p);
        coef_t r;
        word_t om[3];
        word_t u[3];
        word_t pxx, pyy, pzz, pxy, pxz, pyz, s, dn, c0, d, k;
        word_t one;
        logic [63:0] num, dv;
        one = 32'sd1 <<< FRAC_BITS;
        for (int i = 0; i < 3; i++)
        begin
            om[i] = fx_mul(rot_f, p.b[i]);
            u[i] = flow_en ? fx_sum(p.v[i], -p.f[i], 0) : p.v[i];
            if (flow_en && p.f[i] == 32'sh8000_0000)
                u[i] = sat_w(66'(p.v[i]) + 66'sd2147483648);
        end
        pxx = fx_mul(om[0], om[0]);
        pyy = fx_mul(om[1], om[1]);
        pzz = fx_mul(om[2], om[2]);
        pxy = fx_mul(om[0], om[1]);
        pxz = fx_mul(om[0], om[2]);
        pyz = fx_mul(om[1], om[2]);
        s = fx_sum(pxx, pyy, pzz);
        dv = 64'(66'(one) + 66'(s));
        num = 64'd1 << (2 * FRAC_BITS);
        dn = word_t'((num + (dv >> 1)) / dv);
        c0 = fx_mul(fx_mul(fx_mul(dn, inv_v), p.q), rot_f);
        r.m[0] = fx_mul(fx_sum(one, pxx, 0), c0);
        r.m[1] = fx_mul(fx_sum(om[2], pxy, 0), c0);
        r.m[2] = fx_mul(sat_w(66'(pxz) - 66'(om[1])), c0);
        r.m[3] = fx_mul(sat_w(66'(pxy) - 66'(om[2])), c0);
        r.m[4] = fx_mul(fx_sum(one, pyy, 0), c0);
        r.m[5] = fx_mul(fx_sum(om[0], pyz, 0), c0);
        r.m[6] = fx_mul(fx_sum(om[1], pxz, 0), c0);
        r.m[7] = fx_mul(sat_w(66'(pyz) - 66'(om[0])), c0);
        r.m[8] = fx_mul(fx_sum(one, pzz, 0), c0);
        d = fx_sum(fx_mul(u[0], om[0]), fx_mul(u[1], om[1]), fx_mul(u[2], om[2]));
        k = fx_mul(dn, p.q);
        for (int i = 0; i < 3; i++)
            r.c[i] = fx_mul(fx_sum(u[i], sat_w(66'(fx_mul(u[(i+1)%3], om[(i+2)%3]))
                - 66'(fx_mul(u[(i+2)%3], om[(i+1)%3])) + 66'(fx_mul(d, om[i]))), 0), k);
        return r;
    endfunction

    task automatic report_mismatch(string what, int idx, word_t got, word_t want);
        $display("mismatch %s[%0d] at result %0d: got %h want %h",
            what, idx, n_checked, got, want);
        n_errors++;
    endtask

    // input driver: bursts and gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
            {b_x, b_y, b_z, vel_x, vel_y, vel_z, flow_x, flow_y, flow_z} <= '0;
            particle_charge <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                expected_coefs.push_back(predict_coefs(pending.pop_front()));
                n_sent++;
            end
            if (gap_left > 0 || pending.size() == 0 || cfg_valid)
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                in_valid <= 1'b1;
                {b_x, b_y, b_z} <= {pending[0].b[0], pending[0].b[1], pending[0].b[2]};
                {vel_x, vel_y, vel_z} <= {pending[0].v[0], pending[0].v[1], pending[0].v[2]};
                {flow_x, flow_y, flow_z} <= {pending[0].f[0], pending[0].f[1],
                    pending[0].f[2]};
                particle_charge <= pending[0].q;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // output monitor with its own stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_phase <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            case ((stall_phase / 200) % 3)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ($urandom_range(0, 2) == 0);
            endcase
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_valid)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && out_ready)
            begin
                if (expected_coefs.size() == 0)
                begin
                    $display("unexpected result at %0t", $realtime);
                    n_errors++;
                end
                else
                begin
                    coef_t e;
                    word_t got_m[9];
                    word_t got_c[3];
                    e = expected_coefs.pop_front();
                    got_m = '{m_xx, m_xy, m_xz, m_yx, m_yy, m_yz, m_zx, m_zy, m_zz};
                    got_c = '{cur_x, cur_y, cur_z};
                    for (int i = 0; i < 9; i++)
                        if (got_m[i] !== e.m[i])
                            report_mismatch("m", i, got_m[i], e.m[i]);
                    for (int i = 0; i < 3; i++)
                        if (got_c[i] !== e.c[i])
                            report_mismatch("cur", i, got_c[i], e.c[i]);
                end
                n_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired, %0d results outstanding", expected_coefs.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic word_t rand_word(int mode);
        case (mode)
            0: return $urandom;
            1: return word_t'($urandom_range(0, 8 << FRAC_BITS)) - (4 <<< FRAC_BITS);
            2: return word_t'($urandom_range(0, 1 << 12)) - (1 <<< 11);
            default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    function automatic particle_t rand_particle(int mode);
        particle_t p;
        int m;
        for (int i = 0; i < 3; i++)
        begin
            m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : mode;
            p.b[i] = rand_word(m);
            p.v[i] = rand_word(m);
            p.f[i] = rand_word(m);
        end
        p.q = rand_word(($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : mode);
        return p;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ROT: rot_f = val;
            REG_INV: inv_v = val;
            REG_FLOW: flow_en = val[0];
            default: ;
        endcase
    endtask

    task automatic drain_pipe();
        while (pending.size() != 0 || in_valid || expected_coefs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_directed();
        particle_t p;
        word_t ext[4];
        ext = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh1 <<< FRAC_BITS};
        for (int j = 0; j < 4; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p.b[i] = ext[j];
                p.v[i] = ext[(j + 1) % 4];
                p.f[i] = ext[(j + 2) % 4];
            end
            p.q = ext[(j + 3) % 4];
            pending.push_back(p);
        end
        p.b = '{32'sh1_0000, 32'sh0, 32'sh0};
        p.v = '{32'sh1_0000, 32'sh2_0000, 32'shFFFF_0000};
        p.f = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh1};
        p.q = 32'sh1_0000;
        pending.push_back(p);
        for (int i = 0; i < 3; i++)
            pending.push_back(rand_particle(i));
    endtask

    initial
    begin
        logic [31:0] rot_set[6];
        logic [31:0] inv_set[6];
        rot_set = '{32'h0000_8000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
            32'hFFFF_C000, 32'h0001_0000};
        inv_set = '{32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0100,
            32'hFFFF_0000, 32'h0000_4000};
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_ROT;
        cfg_data = '0;
        rot_f = 32'sh0;
        inv_v = 32'sh1 <<< FRAC_BITS;
        flow_en = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset values first
        queue_directed();
        drain_pipe();
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph < 6)
            begin
                write_reg(REG_ROT, rot_set[ph]);
                write_reg(REG_INV, inv_set[ph]);
            end
            else
            begin
                write_reg(REG_ROT, $urandom);
                write_reg(REG_INV, $urandom);
            end
            write_reg(REG_FLOW, {$urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0, ph[0]});
            write_reg(REG_UNUSED, $urandom);
            if (ph == 0)
                queue_directed();
            for (int i = 0; i < 210; i++)
                pending.push_back(rand_particle($urandom_range(0, 2)));
            drain_pipe();
        end
        $display("sent %0d particles, checked %0d results over 9 register settings",
            n_sent, n_checked);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
+incdir+rtl
rtl/ipmm_pkg.sv
rtl/ipmm_front.sv
rtl/ipmm_div.sv
rtl/ipmm_back.sv
rtl/implicit_pic_mass_matrix_coef.sv
rtl/ipmm_checker.sv
tb/implicit_pic_mass_matrix_coef_tb.sv
